// ----- hdl/csr_pkg.sv -----
package csr_pkg;

	localparam int BYTE_W    = 8;
	localparam int BIT_SEL_W = 3;
	localparam int REQ_W     = 3;
	// register index carried in a command, wide enough for chains of up to eight registers
	localparam int CMD_REG_W = 3;

	localparam logic [REQ_W-1:0] REQ_SET_BIT    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_WR_BYTE    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_ZEROS      = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ONES       = 3'd3;
	localparam logic [REQ_W-1:0] REQ_FLUSH      = 3'd4;
	localparam logic [REQ_W-1:0] REQ_ONE_HOT_FL = 3'd5;
	localparam logic [REQ_W-1:0] REQ_ZEROS_FL   = 3'd6;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_SET_BIT,
		CMD_WR_BYTE,
		CMD_FILL
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t               op;
		logic                  flush;
		logic                  fill_val;
		logic                  one_hot;   // clear all before the byte write
		logic [CMD_REG_W-1:0]  reg_idx;
		logic [BIT_SEL_W-1:0]  bit_idx;
		logic                  bit_val;
		logic [BYTE_W-1:0]     byte_val;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_SHIFT
	} bk_state_t;

endpackage

// ----- hdl/csr_if.sv -----
interface csr_req_if import csr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [7:0]        reg_index;
	logic [7:0]        bit_number;
	logic              bit_value;
	logic [BYTE_W-1:0] byte_value;
	logic [7:0]        one_hot_position;

	modport source (output valid, req_type, reg_index, bit_number, bit_value, byte_value,
		one_hot_position, input ready);
	modport sink (input valid, req_type, reg_index, bit_number, bit_value, byte_value,
		one_hot_position, output ready);
endinterface

interface csr_res_if;
	logic valid;
	logic ready;
	logic serial_bit;
	logic latch_after;

	modport source (output valid, serial_bit, latch_after, input ready);
	modport sink (input valid, serial_bit, latch_after, output ready);
endinterface

interface csr_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- hdl/chained_shift_register_output_driver_top.sv -----
// channel | dir | payload                                        | accepted when
// req     | in  | req_type reg_index bit_number bit_value        | req.valid && req.ready
//         |     | byte_value one_hot_position                    |
// res     | out | serial_bit latch_after                         | res.valid && res.ready
// cfg     | in  | data (msb_first)                               | cfg.valid && cfg.ready
//
// A non-flushing request is applied in the back end as it is popped; a flush shifts out
// REG_COUNT*8 bits, one bit per cycle from the shift counter while res is not stalled.
// A two-entry command queue lets the front take requests while a flush is shifting.
// Reset clears the image to zeros and sets msb_first; no clearing pass is needed.
// A stalled res holds the shifter; req stalls only when the command queue is full.
module chained_shift_register_output_driver_top import csr_pkg::*; #(
	parameter int REG_COUNT = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	csr_req_if.sink   req,
	csr_res_if.source res,
	csr_cfg_if.sink   cfg
);

	logic msb_first_q;
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msb_first_q <= 1'b1;
		end else if (cfg.valid) begin
			msb_first_q <= cfg.data;
		end
	end

	csr_front #(.REG_COUNT(REG_COUNT)) u_front (
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	csr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	csr_back #(.REG_COUNT(REG_COUNT)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.msb_first (msb_first_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.res       (res)
	);

endmodule

// ----- hdl/csr_front.sv -----
module csr_front import csr_pkg::*; #(
	parameter int REG_COUNT = 4
) (
	csr_req_if.sink req,
	output logic    push_valid,
	input  logic    push_ready,
	output cmd_t    push_cmd
);

	logic reg_ok;
	logic bit_ok;
	logic hot_ok;
	logic keep;

	assign reg_ok = req.reg_index < 8'(REG_COUNT);
	assign bit_ok = req.bit_number < 8'(BYTE_W);
	assign hot_ok = req.one_hot_position[7:3] < 5'(REG_COUNT);

	always_comb begin
		push_cmd          = '0;
		push_cmd.op       = CMD_NONE;
		push_cmd.reg_idx  = req.reg_index[CMD_REG_W-1:0];
		push_cmd.bit_idx  = req.bit_number[BIT_SEL_W-1:0];
		push_cmd.bit_val  = req.bit_value;
		push_cmd.byte_val = req.byte_value;
		keep              = 1'b1;
		unique case (req.req_type)
			REQ_SET_BIT: begin
				push_cmd.op = CMD_SET_BIT;
				keep        = reg_ok && bit_ok;
			end
			REQ_WR_BYTE: begin
				push_cmd.op = CMD_WR_BYTE;
				keep        = reg_ok;
			end
			REQ_ZEROS: begin
				push_cmd.op = CMD_FILL;
			end
			REQ_ONES: begin
				push_cmd.op       = CMD_FILL;
				push_cmd.fill_val = 1'b1;
			end
			REQ_FLUSH: begin
				push_cmd.flush = 1'b1;
			end
			REQ_ONE_HOT_FL: begin
				push_cmd.op       = CMD_WR_BYTE;
				push_cmd.one_hot  = 1'b1;
				push_cmd.flush    = 1'b1;
				push_cmd.reg_idx  = req.one_hot_position[3 +: CMD_REG_W];
				push_cmd.byte_val = BYTE_W'(1) << req.one_hot_position[BIT_SEL_W-1:0];
				keep              = hot_ok;
			end
			REQ_ZEROS_FL: begin
				push_cmd.op    = CMD_FILL;
				push_cmd.flush = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// dropped requests are taken without waiting for queue space
	assign req.ready  = push_ready || !keep;
	assign push_valid = req.valid && keep;

endmodule

// ----- hdl/csr_fifo.sv -----
module csr_fifo import csr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ----- hdl/csr_back.sv -----
module csr_back import csr_pkg::*; #(
	parameter int REG_COUNT = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msb_first,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  cmd_t      pop_cmd,
	csr_res_if.source res
);

	localparam int TOTAL  = REG_COUNT * BYTE_W;
	localparam int CNT_W  = $clog2(TOTAL);
	localparam int RIDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	bk_state_t                         state_q;
	bk_state_t                         state_d;
	logic [REG_COUNT-1:0][BYTE_W-1:0]  image_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic                              out_valid_q;
	logic                              out_bit_q;
	logic                              out_latch_q;
	logic                              load;
	logic                              last;
	logic [RIDX_W-1:0]                 reg_sel;
	logic [RIDX_W-1:0]                 wr_sel;
	logic [BIT_SEL_W-1:0]              bit_sel;
	logic [TOTAL-1:0]                  hot_image;

	// registers go out from the last one down
	assign reg_sel = RIDX_W'(REG_COUNT - 1) - RIDX_W'(cnt_q >> BIT_SEL_W);
	assign bit_sel = msb_first ? ~cnt_q[BIT_SEL_W-1:0] : cnt_q[BIT_SEL_W-1:0];
	assign last    = cnt_q == CNT_W'(TOTAL - 1);
	assign wr_sel  = pop_cmd.reg_idx[RIDX_W-1:0];
	// whole image with only the addressed byte written, the rest cleared
	assign hot_image = TOTAL'(pop_cmd.byte_val) << {wr_sel, BIT_SEL_W'(0)};

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid && pop_cmd.flush) state_d = BK_SHIFT;
			end
			BK_SHIFT: begin
				load = !out_valid_q || res.ready;
				if (load && last) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			image_q     <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				cnt_q       <= last ? '0 : cnt_q + CNT_W'(1);
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop_valid && pop_ready) begin
				case (pop_cmd.op)
					CMD_SET_BIT: image_q[wr_sel][pop_cmd.bit_idx] <= pop_cmd.bit_val;
					CMD_WR_BYTE: begin
						if (pop_cmd.one_hot) begin
							image_q <= hot_image;
						end else begin
							image_q[wr_sel] <= pop_cmd.byte_val;
						end
					end
					CMD_FILL: image_q <= {(REG_COUNT * BYTE_W){pop_cmd.fill_val}};
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_bit_q   <= image_q[reg_sel][bit_sel];
			out_latch_q <= last;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.serial_bit  = out_bit_q;
	assign res.latch_after = out_latch_q;

endmodule

// ----- hdl/csr_checker.sv -----
module csr_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic res_serial_bit,
	input logic res_latch_after
);

	// held result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_serial_bit) && $stable(res_latch_after))
		else $error("result changed while stalled");

	// within a flush the next bit is loaded as the current one is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_latch_after |=> res_valid)
		else $error("gap inside a flush");

	assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(res_valid))
		else $error("result valid unknown out of reset");

endmodule

bind chained_shift_register_output_driver_top csr_checker u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_serial_bit  (res.serial_bit),
	.res_latch_after (res.latch_after)
);

// ----- test/chained_shift_register_output_driver_top_tb.sv -----
`timescale 1ns / 100ps

module chained_shift_register_output_driver_top_tb;
	import csr_pkg::*;

	localparam int REG_COUNT = 4;
	localparam int CHAIN_BITS = REG_COUNT * BYTE_W;
	// one full flush plus slack for the command queue
	localparam int SETTLE_CYCLES = CHAIN_BITS + 8;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

	typedef struct packed {
		logic serial_bit;
		logic latch_after;
	} shift_bit_t;

	logic clk;
	logic arst_n;

	csr_req_if req_ch ();
	csr_res_if res_ch ();
	csr_cfg_if cfg_ch ();

	chained_shift_register_output_driver_top #(
		.REG_COUNT(REG_COUNT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	logic [BYTE_W-1:0] image_model [REG_COUNT] = '{default: '0};
	logic msb_first_model = 1'b1;
	shift_bit_t pending_bits [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int res_idle_pct = 30;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("[chained_shift_register_output_driver_top] ERROR");
		$finish;
	end

	// push the bits of one flush: last register first, latch on the final bit
	task automatic push_flush();
		shift_bit_t b;
		for (int r = REG_COUNT - 1; r >= 0; r--) begin
			for (int k = 0; k < BYTE_W; k++) begin
				b.serial_bit = msb_first_model ? image_model[r][BYTE_W-1-k] : image_model[r][k];
				b.latch_after = (r == 0) && (k == BYTE_W - 1);
				pending_bits.push_back(b);
			end
		end
	endtask

	task automatic predict_request(input logic [REQ_W-1:0] kind, input logic [7:0] ridx,
		input logic [7:0] bnum, input logic bval, input logic [7:0] bytev, input logic [7:0] pos);
		case (kind)
			REQ_SET_BIT: begin
				if (ridx < REG_COUNT && bnum < BYTE_W)
					image_model[ridx][bnum[BIT_SEL_W-1:0]] = bval;
			end
			REQ_WR_BYTE: begin
				if (ridx < REG_COUNT)
					image_model[ridx] = bytev;
			end
			REQ_ZEROS: image_model = '{default: '0};
			REQ_ONES: image_model = '{default: '1};
			REQ_FLUSH: push_flush();
			REQ_ONE_HOT_FL: begin
				if (pos[7:3] < REG_COUNT) begin
					image_model = '{default: '0};
					image_model[pos[7:3]][pos[2:0]] = 1'b1;
					push_flush();
				end
			end
			REQ_ZEROS_FL: begin
				image_model = '{default: '0};
				push_flush();
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				msb_first_model = cfg_ch.data;
			if (req_ch.valid && req_ch.ready)
				predict_request(req_ch.req_type, req_ch.reg_index, req_ch.bit_number,
					req_ch.bit_value, req_ch.byte_value, req_ch.one_hot_position);
		end
	end

	always @(posedge clk) begin
		shift_bit_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_bits.size() == 0) begin
				$error("serial_bit: expected no item, got %0b", res_ch.serial_bit);
				mismatches++;
			end else begin
				want = pending_bits.pop_front();
				if (res_ch.serial_bit !== want.serial_bit) begin
					$error("serial_bit: expected %0b, got %0b", want.serial_bit,
						res_ch.serial_bit);
					mismatches++;
				end
				if (res_ch.latch_after !== want.latch_after) begin
					$error("latch_after: expected %0b, got %0b", want.latch_after,
						res_ch.latch_after);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk)
		res_ch.ready <= ($urandom_range(0, 99) >= res_idle_pct);

	task automatic send_item(input logic [REQ_W-1:0] kind, input logic [7:0] ridx,
		input logic [7:0] bnum, input logic bval, input logic [7:0] bytev, input logic [7:0] pos);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.reg_index <= ridx;
		req_ch.bit_number <= bnum;
		req_ch.bit_value <= bval;
		req_ch.byte_value <= bytev;
		req_ch.one_hot_position <= pos;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// sender goes quiet until every pending bit is out and the back end settles
	task automatic wait_chain_idle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_bits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_bit_order(input logic msb);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= msb;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_flush_after_reset();
		send_item(REQ_FLUSH, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF);
	endtask

	task automatic test_bit_and_byte_requests();
		send_item(REQ_SET_BIT, 8'd0, 8'd0, 1'b1, 8'h00, 8'h00);
		send_item(REQ_SET_BIT, 8'd3, 8'd7, 1'b1, 8'h00, 8'h00);
		// out-of-range bit or register: ignored
		send_item(REQ_SET_BIT, 8'd0, 8'd8, 1'b1, 8'h00, 8'h00);
		send_item(REQ_SET_BIT, 8'd4, 8'd1, 1'b1, 8'h00, 8'h00);
		send_item(REQ_SET_BIT, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF);
		send_item(REQ_WR_BYTE, 8'd1, 8'h00, 1'b0, 8'hA5, 8'h00);
		send_item(REQ_WR_BYTE, 8'hFF, 8'h00, 1'b0, 8'hFF, 8'h00);
		send_item(REQ_SET_BIT, 8'd3, 8'd7, 1'b0, 8'hFF, 8'hFF);
		send_item(REQ_FLUSH, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
	endtask

	task automatic test_fill_requests();
		send_item(REQ_ONES, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
		send_item(REQ_FLUSH, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
		send_item(REQ_ZEROS, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF);
		send_item(REQ_ONES, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
		send_item(REQ_ZEROS_FL, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
	endtask

	task automatic test_one_hot_flush();
		send_item(REQ_ONE_HOT_FL, 8'h00, 8'h00, 1'b0, 8'h00, 8'd0);
		send_item(REQ_ONE_HOT_FL, 8'h00, 8'h00, 1'b0, 8'h00, 8'(CHAIN_BITS - 1));
		// past the chain: no change and no flush
		send_item(REQ_ONE_HOT_FL, 8'h00, 8'h00, 1'b0, 8'h00, 8'(CHAIN_BITS));
		send_item(REQ_ONE_HOT_FL, 8'h00, 8'h00, 1'b0, 8'h00, 8'hFF);
		send_item(REQ_UNUSED, 8'h00, 8'h00, 1'b1, 8'hFF, 8'd13);
	endtask

	task automatic test_lsb_first_order();
		wait_chain_idle();
		write_bit_order(1'b0);
		send_item(REQ_WR_BYTE, 8'd0, 8'h00, 1'b0, 8'h01, 8'h00);
		send_item(REQ_WR_BYTE, 8'd3, 8'h00, 1'b0, 8'hC0, 8'h00);
		send_item(REQ_FLUSH, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
		send_item(REQ_ONE_HOT_FL, 8'h00, 8'h00, 1'b0, 8'h00, 8'd9);
		wait_chain_idle();
		write_bit_order(1'b1);
	endtask

	task automatic test_pause_until_drained();
		send_item(REQ_FLUSH, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
		wait_chain_idle();
		send_item(REQ_ZEROS_FL, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
	endtask

	task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
		input int items, input logic msb);
		logic [REQ_W-1:0] kind;
		logic [7:0] ridx;
		logic [7:0] bnum;
		logic [7:0] bytev;
		logic [7:0] pos;
		logic bval;
		logic useful;
		int sel;
		int done;
		wait_chain_idle();
		write_bit_order(msb);
		send_idle_pct = sender_pct;
		res_idle_pct = receiver_pct;
		done = 0;
		while (done < items) begin
			sel = $urandom_range(0, 99);
			if (sel < 30)
				kind = REQ_SET_BIT;
			else if (sel < 50)
				kind = REQ_WR_BYTE;
			else if (sel < 56)
				kind = REQ_ZEROS;
			else if (sel < 62)
				kind = REQ_ONES;
			else if (sel < 74)
				kind = REQ_FLUSH;
			else if (sel < 86)
				kind = REQ_ONE_HOT_FL;
			else if (sel < 94)
				kind = REQ_ZEROS_FL;
			else
				kind = REQ_W'($urandom_range(0, 7));
			// mostly in range, now and then anything the field allows
			ridx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(0, REG_COUNT - 1));
			bnum = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(0, BYTE_W - 1));
			pos = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(0, CHAIN_BITS - 1));
			bval = 1'($urandom_range(0, 1));
			bytev = 8'($urandom_range(0, 255));
			case (kind)
				REQ_SET_BIT: useful = (ridx < REG_COUNT) && (bnum < BYTE_W);
				REQ_WR_BYTE: useful = (ridx < REG_COUNT);
				REQ_ONE_HOT_FL: useful = (pos[7:3] < REG_COUNT);
				REQ_UNUSED: useful = 1'b0;
				default: useful = 1'b1;
			endcase
			send_item(kind, ridx, bnum, bval, bytev, pos);
			if (useful)
				done++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_SET_BIT;
		req_ch.reg_index = '0;
		req_ch.bit_number = '0;
		req_ch.bit_value = 1'b0;
		req_ch.byte_value = '0;
		req_ch.one_hot_position = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_flush_after_reset();
		test_bit_and_byte_requests();
		test_fill_requests();
		test_one_hot_flush();
		test_lsb_first_order();
		test_pause_until_drained();
		test_random_traffic(9, 65, 160, 1'b1);
		test_random_traffic(65, 9, 160, 1'b0);
		test_random_traffic(0, 0, 160, 1'b1);
		wait_chain_idle();

		if (mismatches == 0 && pending_bits.size() == 0) begin
			$display("[chained_shift_register_output_driver_top] OK");
		end else begin
			$display("[chained_shift_register_output_driver_top] ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/csr_pkg.sv
hdl/csr_if.sv
hdl/csr_front.sv
hdl/csr_fifo.sv
hdl/csr_back.sv
hdl/chained_shift_register_output_driver_top.sv
hdl/csr_checker.sv
test/chained_shift_register_output_driver_top_tb.sv
